[hdl/dece_pkg.sv]
`timescale 1ns / 1ps

package dece_pkg;

	// configuration register indexes
	localparam logic [1:0] REG_VIDEO_MODE      = 2'd0;
	localparam logic [1:0] REG_CONTROLLER_KIND = 2'd1;
	localparam logic [1:0] REG_REVERSE_FLAG    = 2'd2;

	// controller kinds that take the 12/12 start format
	localparam logic [7:0] KIND_WIDE_A = 8'd1;
	localparam logic [7:0] KIND_WIDE_B = 8'd2;

	// command opcodes
	localparam logic [31:0] CMD_START  = 32'h0500_0000;
	localparam logic [31:0] CMD_HRANGE = 32'h0600_0000;
	localparam logic [31:0] CMD_VRANGE = 32'h0700_0000;
	localparam logic [31:0] CMD_MODE   = 32'h0800_0000;

	// horizontal range math, 22-bit signed
	localparam int HW = 22;
	localparam logic signed [HW-1:0] H_START_OFS    = 22'sh260;
	localparam logic signed [HW-1:0] H_DEFAULT_SPAN = 22'shA00;
	localparam logic signed [HW-1:0] H_MIN          = 22'sh1F4;
	localparam logic signed [HW-1:0] H_MAX          = 22'shCDA;
	localparam logic signed [HW-1:0] H_MIN_SPAN     = 22'sh50;

	// vertical range math, 18-bit signed
	localparam int VW = 18;
	localparam logic signed [VW-1:0] V_OFS_PAL      = 18'sh13;
	localparam logic signed [VW-1:0] V_OFS_NTSC     = 18'sh10;
	localparam logic signed [VW-1:0] V_DEFAULT_SPAN = 18'shF0;
	localparam logic signed [VW-1:0] V_MIN          = 18'sh10;
	localparam logic signed [VW-1:0] V_MAX_PAL      = 18'sh136;
	localparam logic signed [VW-1:0] V_MAX_NTSC     = 18'sh100;
	localparam logic signed [VW-1:0] V_END_PAL      = 18'sh138;
	localparam logic signed [VW-1:0] V_END_NTSC     = 18'sh102;
	localparam logic signed [VW-1:0] V_MIN_SPAN     = 18'sh2;

	// width bands and height limits for the mode word
	localparam logic signed [15:0] W_BAND_0 = 16'sh118;
	localparam logic signed [15:0] W_BAND_1 = 16'sh160;
	localparam logic signed [15:0] W_BAND_2 = 16'sh190;
	localparam logic signed [15:0] W_BAND_3 = 16'sh230;
	localparam logic signed [15:0] H_LIM_PAL  = 16'sh120;
	localparam logic signed [15:0] H_LIM_NTSC = 16'sh100;

	// queue between front and back end
	localparam int Q_DEPTH = 2;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	typedef struct packed {
		logic       video_mode;
		logic [7:0] controller_kind;
		logic       reverse_flag;
	} cfg_t;

	// classified record waiting for the clamp and pack step
	typedef struct packed {
		logic [31:0]             start_word;
		logic [31:0]             mode_word;
		logic                    scr_diff;
		logic                    mode_diff;
		logic                    pal;
		logic signed [HW-1:0]    hs_raw;
		logic signed [HW-1:0]    he_raw;
		logic signed [VW-1:0]    vs_raw;
		logic signed [VW-1:0]    ve_raw;
	} rec_s1_t;

	// up to four words for one record, last_idx is the final one
	typedef struct packed {
		logic [3:0][31:0] words;
		logic [1:0]       last_idx;
	} bundle_t;

endpackage

[hdl/dece_rec_if.sv]
`timescale 1ns / 1ps

interface dece_rec_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] disp_x;
	logic signed [15:0] disp_y;
	logic signed [15:0] disp_w;
	logic signed [15:0] disp_h;
	logic signed [15:0] screen_x;
	logic signed [15:0] screen_y;
	logic signed [15:0] screen_w;
	logic signed [15:0] screen_h;
	logic [7:0]         interlace;
	logic [7:0]         color24;
	logic [15:0]        reserved_bytes;
	logic [11:0]        alt_start_x;

	modport source (
		output valid, disp_x, disp_y, disp_w, disp_h, screen_x, screen_y, screen_w,
			screen_h, interlace, color24, reserved_bytes, alt_start_x,
		input  ready
	);
	modport sink (
		input  valid, disp_x, disp_y, disp_w, disp_h, screen_x, screen_y, screen_w,
			screen_h, interlace, color24, reserved_bytes, alt_start_x,
		output ready
	);
endinterface

[hdl/dece_cmd_if.sv]
`timescale 1ns / 1ps

interface dece_cmd_if;
	logic        valid;
	logic        ready;
	logic [31:0] command_word;
	logic        last;

	modport source (output valid, command_word, last, input ready);
	modport sink (input valid, command_word, last, output ready);
endinterface

[hdl/dece_cfg_if.sv]
`timescale 1ns / 1ps

interface dece_cfg_if;
	logic       valid;
	logic       ready;
	logic [1:0] index;
	logic [7:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

[hdl/dece_cfg_regs.sv]
`timescale 1ns / 1ps

module dece_cfg_regs import dece_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	dece_cfg_if.sink   cfg,
	output cfg_t       cfg_r
);

	cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign cfg_r     = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q <= '0;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_VIDEO_MODE: begin
					regs_q.video_mode <= cfg.data[0];
				end
				REG_CONTROLLER_KIND: begin
					regs_q.controller_kind <= cfg.data;
				end
				REG_REVERSE_FLAG: begin
					regs_q.reverse_flag <= cfg.data[0];
				end
				default: begin
				end
			endcase
		end
	end

endmodule

[hdl/dece_front.sv]
`timescale 1ns / 1ps

module dece_front import dece_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	dece_rec_if.sink  rec,
	input  cfg_t      cfg_r,
	output logic      push_valid,
	input  logic      push_ready,
	output bundle_t   push_data
);

	logic [63:0] saved_disp_q;
	logic [63:0] saved_scr_q;
	logic [31:0] saved_flags_q;

	logic    valid_s1;
	rec_s1_t rec_s1;

	logic          accept;
	logic [63:0]   disp_now;
	logic [63:0]   scr_now;
	logic          scr_diff;
	logic          mode_diff;
	logic [7:0]    mb1;
	logic [7:0]    mb2;
	logic [31:0]   flags1;
	logic [31:0]   flags2;
	rec_s1_t       cls;

	logic signed [HW-1:0] sx_ext;
	logic signed [HW-1:0] sw_ext;
	logic signed [HW-1:0] sx10;
	logic signed [HW-1:0] sw10;
	logic signed [VW-1:0] sy_ext;
	logic signed [VW-1:0] sh_ext;

	logic signed [HW-1:0] hs_c;
	logic signed [HW-1:0] he_lo;
	logic signed [HW-1:0] he_c;
	logic signed [VW-1:0] vs_c;
	logic signed [VW-1:0] vs_hi;
	logic signed [VW-1:0] ve_lo;
	logic signed [VW-1:0] ve_hi;
	logic signed [VW-1:0] ve_c;
	logic [31:0]          h_word;
	logic [31:0]          v_word;

	assign rec.ready = !valid_s1 || push_ready;
	assign accept    = rec.valid && rec.ready;

	// classify against the stored copy
	always_comb begin
		disp_now  = {rec.disp_h, rec.disp_w, rec.disp_y, rec.disp_x};
		scr_now   = {rec.screen_h, rec.screen_w, rec.screen_y, rec.screen_x};
		scr_diff  = scr_now != saved_scr_q;
		mb1       = scr_diff ? {7'd0, cfg_r.video_mode} : rec.reserved_bytes[7:0];
		flags1    = {rec.reserved_bytes[15:8], mb1, rec.color24, rec.interlace};
		mode_diff = (flags1 != saved_flags_q) || (disp_now != saved_disp_q);
		mb2       = mode_diff ? {7'd0, cfg_r.video_mode} : mb1;
		flags2    = {rec.reserved_bytes[15:8], mb2, rec.color24, rec.interlace};
	end

	// raw range sums, times ten as shift and add
	always_comb begin
		sx_ext = {{(HW-16){rec.screen_x[15]}}, rec.screen_x};
		sw_ext = {{(HW-16){rec.screen_w[15]}}, rec.screen_w};
		sx10   = (sx_ext <<< 3) + (sx_ext <<< 1);
		sw10   = (sw_ext <<< 3) + (sw_ext <<< 1);
		sy_ext = {{(VW-16){rec.screen_y[15]}}, rec.screen_y};
		sh_ext = {{(VW-16){rec.screen_h[15]}}, rec.screen_h};

		cls          = '0;
		cls.scr_diff  = scr_diff;
		cls.mode_diff = mode_diff;
		cls.pal       = cfg_r.video_mode;
		cls.hs_raw    = sx10 + H_START_OFS;
		cls.he_raw    = sx10 + H_START_OFS + ((rec.screen_w != 16'sd0) ? sw10 : H_DEFAULT_SPAN);
		cls.vs_raw    = sy_ext + (cfg_r.video_mode ? V_OFS_PAL : V_OFS_NTSC);
		cls.ve_raw    = sy_ext + (cfg_r.video_mode ? V_OFS_PAL : V_OFS_NTSC)
			+ ((rec.screen_h != 16'sd0) ? sh_ext : V_DEFAULT_SPAN);

		if ((cfg_r.controller_kind == KIND_WIDE_A) || (cfg_r.controller_kind == KIND_WIDE_B)) begin
			cls.start_word = CMD_START | {8'd0, rec.disp_y[11:0], rec.alt_start_x};
		end else begin
			cls.start_word = CMD_START | {12'd0, rec.disp_y[9:0], rec.disp_x[9:0]};
		end

		cls.mode_word = CMD_MODE;
		if (cfg_r.video_mode)
			cls.mode_word[3] = 1'b1;
		if (rec.color24 != 8'd0)
			cls.mode_word[4] = 1'b1;
		if (rec.interlace != 8'd0)
			cls.mode_word[5] = 1'b1;
		if (cfg_r.reverse_flag)
			cls.mode_word[7] = 1'b1;
		if (rec.disp_w > W_BAND_0) begin
			if (rec.disp_w <= W_BAND_1)
				cls.mode_word[0] = 1'b1;
			else if (rec.disp_w <= W_BAND_2)
				cls.mode_word[6] = 1'b1;
			else if (rec.disp_w <= W_BAND_3)
				cls.mode_word[1] = 1'b1;
			else
				cls.mode_word[1:0] = 2'b11;
		end
		if (rec.disp_h > (cfg_r.video_mode ? H_LIM_PAL : H_LIM_NTSC)) begin
			cls.mode_word[2] = 1'b1;
			cls.mode_word[5] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			saved_disp_q  <= '0;
			saved_scr_q   <= '0;
			saved_flags_q <= '0;
			valid_s1      <= 1'b0;
		end else begin
			if (accept) begin
				saved_disp_q  <= disp_now;
				saved_scr_q   <= scr_now;
				saved_flags_q <= flags2;
				valid_s1      <= 1'b1;
			end else if (push_ready) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			rec_s1 <= cls;
	end

	// clamp and pack
	always_comb begin
		if (rec_s1.hs_raw < H_MIN)
			hs_c = H_MIN;
		else if (rec_s1.hs_raw > H_MAX)
			hs_c = H_MAX;
		else
			hs_c = rec_s1.hs_raw;

		he_lo = hs_c + H_MIN_SPAN;
		if (rec_s1.he_raw < he_lo)
			he_c = he_lo;
		else if (rec_s1.he_raw > H_MAX)
			he_c = H_MAX;
		else
			he_c = rec_s1.he_raw;

		vs_hi = rec_s1.pal ? V_MAX_PAL : V_MAX_NTSC;
		if (rec_s1.vs_raw < V_MIN)
			vs_c = V_MIN;
		else if (rec_s1.vs_raw > vs_hi)
			vs_c = vs_hi;
		else
			vs_c = rec_s1.vs_raw;

		ve_lo = vs_c + V_MIN_SPAN;
		ve_hi = rec_s1.pal ? V_END_PAL : V_END_NTSC;
		if (rec_s1.ve_raw < ve_lo)
			ve_c = ve_lo;
		else if (rec_s1.ve_raw > ve_hi)
			ve_c = ve_hi;
		else
			ve_c = rec_s1.ve_raw;

		h_word = CMD_HRANGE | {8'd0, he_c[11:0], hs_c[11:0]};
		v_word = CMD_VRANGE | {12'd0, ve_c[9:0], vs_c[9:0]};

		push_data.words[0] = rec_s1.start_word;
		push_data.words[1] = rec_s1.scr_diff ? h_word : rec_s1.mode_word;
		push_data.words[2] = v_word;
		push_data.words[3] = rec_s1.mode_word;
		push_data.last_idx = {rec_s1.scr_diff, rec_s1.mode_diff};
	end

	assign push_valid = valid_s1;

`ifndef SYNTHESIS
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !push_ready |=> valid_s1 && $stable(rec_s1))
		else $error("classified record changed while the queue was full");
`endif

endmodule

[hdl/dece_queue.sv]
`timescale 1ns / 1ps

module dece_queue import dece_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push_valid,
	output logic    push_ready,
	input  bundle_t push_data,
	output logic    pop_valid,
	input  logic    pop_ready,
	output bundle_t pop_data
);

	bundle_t              mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0]   wr_ptr_q;
	logic [Q_PTR_W-1:0]   rd_ptr_q;
	logic [Q_CNT_W-1:0]   cnt_q;
	logic                 push;
	logic                 pop;

	assign push_ready = cnt_q != Q_CNT_W'(Q_DEPTH);
	assign pop_valid  = cnt_q != '0;
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = mem_q[rd_ptr_q];

	// depth is a power of two, pointers wrap on their own
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_data;
	end

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= Q_CNT_W'(Q_DEPTH))
		else $error("queue fill count beyond depth");
`endif

endmodule

[hdl/dece_back.sv]
`timescale 1ns / 1ps

module dece_back import dece_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      head_valid,
	output logic      head_pop,
	input  bundle_t   head,
	dece_cmd_if.source cmd
);

	logic [1:0]  idx_q;
	logic        out_valid_q;
	logic [31:0] word_q;
	logic        last_q;
	logic        load;
	logic        at_last;

	assign load     = head_valid && (!out_valid_q || cmd.ready);
	assign at_last  = idx_q == head.last_idx;
	assign head_pop = load && at_last;

	assign cmd.valid        = out_valid_q;
	assign cmd.command_word = word_q;
	assign cmd.last         = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				idx_q       <= at_last ? 2'd0 : idx_q + 2'd1;
			end else if (cmd.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			word_q <= head.words[idx_q];
			last_q <= at_last;
		end
	end

`ifndef SYNTHESIS
	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		head_valid |-> idx_q <= head.last_idx)
		else $error("word index ran past the end of the record");
	a_idx_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!head_valid |-> idx_q == 2'd0)
		else $error("word index not cleared between records");
	a_pop_last: assert property (@(posedge clk) disable iff (!arst_n)
		head_pop |=> out_valid_q && last_q)
		else $error("record popped without a final word in the output register");
`endif

endmodule

[hdl/display_env_command_encoder_top.sv]
`timescale 1ns / 1ps

// display environment command encoder: each record taken on rec yields one to
// four command words on cmd (start word, then horizontal and vertical range words
// when the screen rectangle changed, then a mode word when the flag bytes or the
// display rectangle changed), the final one marked by last. the front end takes a
// record, compares it with the stored copy and updates that copy at once, so the
// next record can follow in the very next cycle unless the queue is full; a
// two-record queue feeds the back end, which drives one word per cycle through its
// output register while cmd is ready. sustained throughput is set by the single
// output port, which carries each record's one to four words; the first word of a
// record passes the front-end register, the queue and the output register before
// it is valid on cmd. configuration writes on cfg are always taken and should
// only be issued while no record is in flight. no clearing pass after reset.

module display_env_command_encoder_top import dece_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	dece_rec_if.sink   rec,
	dece_cmd_if.source cmd,
	dece_cfg_if.sink   cfg
);

	cfg_t    cfg_r;

	// front end to queue
	logic    push_valid;
	logic    push_ready;
	bundle_t push_data;

	// queue to back end
	logic    head_valid;
	logic    head_pop;
	bundle_t head;

	// video mode, controller kind and reverse flag
	dece_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.cfg_r  (cfg_r)
	);

	// classify, store the record and build the word bundle
	dece_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.rec        (rec),
		.cfg_r      (cfg_r),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	// short queue so front and back stall on their own
	dece_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (head_valid),
		.pop_ready  (head_pop),
		.pop_data   (head)
	);

	// serialize one word per cycle onto the command port while it is ready
	dece_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_pop   (head_pop),
		.head       (head),
		.cmd        (cmd)
	);

endmodule
